// File: rtl/core/b2da_pkg.sv
// b2da_pkg: shared types and constants for the decimal ascii printer
// used by b2da_digit_cell and binary_to_decimal_ascii; no dependencies

package b2da_pkg;

    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;

    // adjust threshold of the shift-add-3 step
    localparam logic [DIGIT_W-1:0] ADJ_MIN   = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // ascii '0', kept to the 6-bit character width
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // per-cycle command broadcast to every digit cell
    typedef struct packed {
        logic clear;        // zero the digit
        logic shift_bit;    // conversion step: adjust, then shift one bit in
        logic shift_digit;  // output step: take the neighbor's digit
    } cell_ctrl_t;

endpackage

// File: rtl/core/binary_to_decimal_ascii.sv
// binary_to_decimal_ascii: top level of the decimal ascii printer
// depends on b2da_pkg and b2da_digit_cell
//
// usage:
//   input channel (in_valid / in_stall / value) takes one unsigned number per
//   transaction; only the low INPUT_BITS bits count (at most the 32 port bits)
//   output channel (out_valid / out_stall / digit_char / last_digit) gives one
//   ascii digit per transaction, most significant first, no leading zeros;
//   zero prints as a single '0'; last_digit marks the least significant digit
// timing:
//   after the input transaction the double-dabble chain shifts in one used
//   input bit per cycle, then walks the digit chain once per digit
//   position: leading zeros are dropped one per cycle, digits are presented
//   one per cycle while out_stall is low
//   in_stall is high from the input transaction until the last digit has
//   been loaded into the output register
// stall: out_stall freezes the output register and, once the leading zeros are
//   dropped, the digit chain; leading zeros are still dropped while stalled
// reset: rst_n clears the controller, the chain and the output valid; the
//   block comes up idle and ready

module binary_to_decimal_ascii
#(
    parameter int INPUT_BITS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [31:0]                    value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [b2da_pkg::CHAR_W-1:0]    digit_char,
    output logic                           last_digit
);

    // bits actually carried by the 32-bit input port
    localparam int USED_BITS = (INPUT_BITS < 32) ? INPUT_BITS : 32;
    // decimal digits of 2^USED_BITS - 1: floor(n * log10(2)) + 1
    localparam int DIGITS    = (USED_BITS * 1233) / 4096 + 1;
    localparam int BCNT_W    = (USED_BITS > 1) ? $clog2(USED_BITS) : 1;
    localparam int REM_W     = $clog2(DIGITS + 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CONVERT = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0]              state_reg,   state_next;
    logic [USED_BITS-1:0]    bin_reg,     bin_next;
    logic [BCNT_W-1:0]       bcnt_reg,    bcnt_next;
    logic [REM_W-1:0]        remain_reg,  remain_next;
    logic                    started_reg, started_next;
    logic                    out_valid_reg, out_valid_next;
    logic [b2da_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                    last_reg,    last_next;

    b2da_pkg::cell_ctrl_t    ctrl;
    logic                    in_take;
    logic                    out_free;
    logic                    skip_zero;
    logic [b2da_pkg::DIGIT_W-1:0] top_digit;

    // chain wiring: bits ripple up from cell 0, digits move up toward the top
    logic                         carry [DIGITS+1];
    logic [b2da_pkg::DIGIT_W-1:0] dig   [DIGITS];
    logic [b2da_pkg::DIGIT_W-1:0] dig_in[DIGITS];

    assign carry[0]  = bin_reg[USED_BITS-1];
    assign dig_in[0] = '0;

    for (genvar i = 0; i < DIGITS; i++)
    begin : g_cell
        if (i > 0)
        begin : g_link
            assign dig_in[i] = dig[i-1];
        end
        b2da_digit_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .bit_in    (carry[i]),
            .digit_in  (dig_in[i]),
            .bit_out   (carry[i+1]),
            .digit_out (dig[i])
        );
    end

    assign top_digit = dig[DIGITS-1];
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    // drop a leading zero unless it is the only digit left
    assign skip_zero = !started_reg && (top_digit == '0) && (remain_reg != REM_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcnt_next      = bcnt_reg;
        remain_next    = remain_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    bin_next     = value[USED_BITS-1:0];
                    bcnt_next    = BCNT_W'(USED_BITS - 1);
                    started_next = 1'b0;
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctrl.shift_bit = 1'b1;
                bin_next       = bin_reg << 1;
                bcnt_next      = bcnt_reg - BCNT_W'(1);
                if (bcnt_reg == '0)
                begin
                    remain_next = REM_W'(DIGITS);
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (skip_zero)
                begin
                    ctrl.shift_digit = 1'b1;
                    remain_next      = remain_reg - REM_W'(1);
                end
                else if (out_free)
                begin
                    ctrl.shift_digit = 1'b1;
                    remain_next      = remain_reg - REM_W'(1);
                    started_next     = 1'b1;
                    out_valid_next   = 1'b1;
                    char_next        = b2da_pkg::ASCII_ZERO
                                       + b2da_pkg::CHAR_W'(top_digit);
                    last_next        = (remain_reg == REM_W'(1));
                    if (remain_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bcnt_reg      <= '0;
            remain_reg    <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bcnt_reg      <= bcnt_next;
            remain_reg    <= remain_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

`ifndef SYNTH
    // an input transaction always starts a conversion
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_CONVERT))
        else $error("input transaction did not start conversion");

    // the emit phase never runs out of digit positions
    a_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (remain_reg != '0))
        else $error("emit phase with no digits left");

    // a presented last digit during emit belongs to the previous number
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg && (state_reg == ST_EMIT)) |-> !started_reg)
        else $error("last digit presented while still emitting");

    // presented characters are always decimal digits
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg >= b2da_pkg::ASCII_ZERO
                           && char_reg <= b2da_pkg::ASCII_ZERO + 6'd9))
        else $error("output character is not a decimal digit");
`endif

endmodule

// File: rtl/core/b2da_digit_cell.sv
// b2da_digit_cell: one bcd digit of the conversion chain
// depends on b2da_pkg (cell_ctrl_t, digit constants)

module b2da_digit_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  b2da_pkg::cell_ctrl_t           ctrl,
    input  logic                           bit_in,
    input  logic [b2da_pkg::DIGIT_W-1:0]   digit_in,
    output logic                           bit_out,
    output logic [b2da_pkg::DIGIT_W-1:0]   digit_out
);

    logic [b2da_pkg::DIGIT_W-1:0] digit_reg;
    logic [b2da_pkg::DIGIT_W-1:0] digit_next;
    logic [b2da_pkg::DIGIT_W-1:0] adj;

    // add 3 when the digit would reach ten or more after doubling
    assign adj = (digit_reg >= b2da_pkg::ADJ_MIN) ? digit_reg + b2da_pkg::ADJ_ADD
                                                  : digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift_bit)
        begin
            digit_next = {adj[b2da_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift_digit)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign bit_out   = adj[b2da_pkg::DIGIT_W-1];
    assign digit_out = digit_reg;

`ifndef SYNTH
    // a held digit is always a valid decimal digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_reg <= b2da_pkg::DIGIT_MAX)
        else $error("digit cell holds a non-decimal value");
`endif

endmodule
